// File: rtl/core/fcsg_pkg.sv
package fcsg_pkg;

  // coordinate width of the result fields
  localparam int COORD_BITS = 16;

  // fixed widths of the input fields and the walk state
  localparam int CENTER_W  = 16;
  localparam int RADIUS_W  = 14;
  localparam int RUN_X_W   = 16;
  localparam int RUN_Y_W   = 15;
  localparam int ERR_W     = 18;
  localparam int STEP_W    = 17;
  localparam int TWICE_R_W = 15;

  // exact sum width before wrapping to COORD_BITS
  localparam int EXACT_W = (COORD_BITS > 17) ? COORD_BITS + 1 : 18;

  // primitives per octant step
  localparam int NUM_PRIMS = 12;
  localparam int IDX_W     = $clog2(NUM_PRIMS);

  // step queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // result kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_SPAN  = 1'b1;

  // one octant step handed from front to back
  typedef struct packed {
    logic                        done;
    logic signed [CENTER_W-1:0]  cx;
    logic signed [CENTER_W-1:0]  cy;
    logic signed [RUN_X_W-1:0]   x;
    logic        [RUN_Y_W-1:0]   y;
  } job_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

  // operand selection for one primitive
  typedef struct packed {
    logic kind;
    logic col_use_y;
    logic beg_neg;
    logic end_neg;
    logic row_use_y;
    logic row_neg;
  } prim_sel_t;

  // order: eight points, then four fill spans
  function automatic prim_sel_t prim_sel(input logic [IDX_W-1:0] idx);
    prim_sel_t s;
    s = '0;
    unique case (idx)
      IDX_W'(0):  s = '{KIND_POINT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
      IDX_W'(1):  s = '{KIND_POINT, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      IDX_W'(2):  s = '{KIND_POINT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
      IDX_W'(3):  s = '{KIND_POINT, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
      IDX_W'(4):  s = '{KIND_POINT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      IDX_W'(5):  s = '{KIND_POINT, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      IDX_W'(6):  s = '{KIND_POINT, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
      IDX_W'(7):  s = '{KIND_POINT, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0};
      IDX_W'(8):  s = '{KIND_SPAN,  1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      IDX_W'(9):  s = '{KIND_SPAN,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
      IDX_W'(10): s = '{KIND_SPAN,  1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      IDX_W'(11): s = '{KIND_SPAN,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
      default:    s = '0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/fcsg_front.sv
module fcsg_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_operation,
  input  logic signed [fcsg_pkg::CENTER_W-1:0] in_center_x,
  input  logic signed [fcsg_pkg::CENTER_W-1:0] in_center_y,
  input  logic        [fcsg_pkg::RADIUS_W-1:0] in_radius,
  input  fcsg_pkg::q_status_t                  q_st,
  output logic                                 push,
  output fcsg_pkg::job_t                       push_job
);

  logic signed [fcsg_pkg::CENTER_W-1:0]  cx_r, cx_nxt;
  logic signed [fcsg_pkg::CENTER_W-1:0]  cy_r, cy_nxt;
  logic signed [fcsg_pkg::RUN_X_W-1:0]   run_x_r, run_x_nxt;
  logic        [fcsg_pkg::RUN_Y_W-1:0]   run_y_r, run_y_nxt;
  logic signed [fcsg_pkg::ERR_W-1:0]     err_r, err_nxt;
  logic        [fcsg_pkg::STEP_W-1:0]    tx_r, tx_nxt;
  logic        [fcsg_pkg::STEP_W-1:0]    ty_r, ty_nxt;
  logic        [fcsg_pkg::TWICE_R_W-1:0] twice_r_r, twice_r_nxt;

  logic                                  accept;
  logic                                  walk_done;
  logic                                  err_le0;
  logic                                  err1_gt0;
  logic signed [fcsg_pkg::ERR_W-1:0]     err1;
  logic        [fcsg_pkg::STEP_W-1:0]    tx_inc;
  logic        [fcsg_pkg::TWICE_R_W-1:0] twice_new;

  assign in_stall = q_st.full;
  assign accept   = in_valid && !q_st.full;

  // walk is over once x drops below y
  assign walk_done = $signed({run_x_r[fcsg_pkg::RUN_X_W-1], run_x_r})
                   < $signed({2'b00, run_y_r});

  assign err_le0  = err_r[fcsg_pkg::ERR_W-1] || (err_r == '0);
  assign err1     = err_le0 ? err_r + $signed({1'b0, ty_r}) : err_r;
  assign err1_gt0 = !err1[fcsg_pkg::ERR_W-1] && (err1 != '0);
  assign tx_inc   = tx_r + fcsg_pkg::STEP_W'(2);
  assign twice_new = {in_radius, 1'b0};

  assign push = accept && (in_operation == fcsg_pkg::OP_ADVANCE);

  always_comb begin
    push_job.done = walk_done;
    push_job.cx   = cx_r;
    push_job.cy   = cy_r;
    push_job.x    = run_x_r;
    push_job.y    = run_y_r;
  end

  always_comb begin
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    run_x_nxt   = run_x_r;
    run_y_nxt   = run_y_r;
    err_nxt     = err_r;
    tx_nxt      = tx_r;
    ty_nxt      = ty_r;
    twice_r_nxt = twice_r_r;
    if (accept && (in_operation == fcsg_pkg::OP_START)) begin
      cx_nxt      = in_center_x;
      cy_nxt      = in_center_y;
      twice_r_nxt = twice_new;
      run_x_nxt   = fcsg_pkg::RUN_X_W'(in_radius) - fcsg_pkg::RUN_X_W'(1);
      run_y_nxt   = '0;
      tx_nxt      = fcsg_pkg::STEP_W'(1);
      ty_nxt      = fcsg_pkg::STEP_W'(1);
      err_nxt     = fcsg_pkg::ERR_W'(1) - $signed(fcsg_pkg::ERR_W'(twice_new));
    end else if (push && !walk_done) begin
      if (err_le0) begin
        run_y_nxt = run_y_r + fcsg_pkg::RUN_Y_W'(1);
        ty_nxt    = ty_r + fcsg_pkg::STEP_W'(2);
      end
      err_nxt = err1;
      if (err1_gt0) begin
        run_x_nxt = run_x_r - fcsg_pkg::RUN_X_W'(1);
        tx_nxt    = tx_inc;
        err_nxt   = err1 + $signed({1'b0, tx_inc})
                  - $signed(fcsg_pkg::ERR_W'(twice_r_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= '0;
      cy_r      <= '0;
      run_x_r   <= '1;
      run_y_r   <= '0;
      err_r     <= '0;
      tx_r      <= fcsg_pkg::STEP_W'(1);
      ty_r      <= fcsg_pkg::STEP_W'(1);
      twice_r_r <= '0;
    end else begin
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      run_x_r   <= run_x_nxt;
      run_y_r   <= run_y_nxt;
      err_r     <= err_nxt;
      tx_r      <= tx_nxt;
      ty_r      <= ty_nxt;
      twice_r_r <= twice_r_nxt;
    end
  end

endmodule

// File: rtl/core/fcsg_queue.sv
module fcsg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fcsg_pkg::job_t      push_job,
  input  logic                pop,
  output fcsg_pkg::q_status_t q_st,
  output fcsg_pkg::job_t      head_job
);

  fcsg_pkg::job_t                    slot_r [fcsg_pkg::QUEUE_DEPTH];
  logic [fcsg_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [fcsg_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [fcsg_pkg::QCNT_W-1:0]       count_r, count_nxt;
  logic                              do_push;
  logic                              do_pop;

  assign q_st.full       = (count_r == fcsg_pkg::QCNT_W'(fcsg_pkg::QUEUE_DEPTH));
  assign q_st.head_valid = (count_r != '0);
  assign head_job        = slot_r[rd_ptr_r];

  assign do_push = push && !q_st.full;
  assign do_pop  = pop && q_st.head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == fcsg_pkg::QPTR_W'(fcsg_pkg::QUEUE_DEPTH - 1))
                 ? '0 : wr_ptr_r + fcsg_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == fcsg_pkg::QPTR_W'(fcsg_pkg::QUEUE_DEPTH - 1))
                 ? '0 : rd_ptr_r + fcsg_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + fcsg_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - fcsg_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fcsg_pkg::QCNT_W'(fcsg_pkg::QUEUE_DEPTH))
    else $error("queue count past depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_st.head_valid)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

// File: rtl/core/fcsg_back.sv
module fcsg_back (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  fcsg_pkg::q_status_t                      q_st,
  input  fcsg_pkg::job_t                           head_job,
  output logic                                     pop,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     out_kind,
  output logic signed [fcsg_pkg::COORD_BITS-1:0]   out_x_begin,
  output logic signed [fcsg_pkg::COORD_BITS-1:0]   out_x_end,
  output logic signed [fcsg_pkg::COORD_BITS-1:0]   out_row,
  output logic                                     out_last,
  output logic                                     out_done_res,
  output logic                                     out_overflow
);

  localparam int EW = fcsg_pkg::EXACT_W;
  localparam int CW = fcsg_pkg::COORD_BITS;

  fcsg_pkg::job_t                job_r, job_nxt;
  logic                          busy_r, busy_nxt;
  logic [fcsg_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          kind_r, kind_nxt;
  logic signed [CW-1:0]          xb_r, xb_nxt;
  logic signed [CW-1:0]          xe_r, xe_nxt;
  logic signed [CW-1:0]          row_r, row_nxt;
  logic                          last_r, last_nxt;
  logic                          done_r, done_nxt;
  logic                          ovf_r, ovf_nxt;

  fcsg_pkg::prim_sel_t           sel;
  logic                          load_out;
  logic                          step_end;
  logic signed [EW-1:0]          cx_e, cy_e, x_e, y_e;
  logic signed [EW-1:0]          a_col, a_row;
  logic signed [EW-1:0]          beg_ex, end_ex, row_ex;
  logic signed [CW-1:0]          beg_w, end_w, row_w;
  logic                          ovf;

  assign load_out = !out_valid_r || !out_stall;
  assign step_end = job_r.done || (idx_r == fcsg_pkg::IDX_W'(fcsg_pkg::NUM_PRIMS - 1));
  assign pop      = q_st.head_valid && (!busy_r || (load_out && step_end));

  assign sel  = fcsg_pkg::prim_sel(idx_r);
  assign cx_e = EW'($signed(job_r.cx));
  assign cy_e = EW'($signed(job_r.cy));
  assign x_e  = EW'($signed(job_r.x));
  assign y_e  = $signed(EW'(job_r.y));

  assign a_col  = sel.col_use_y ? y_e : x_e;
  assign a_row  = sel.row_use_y ? y_e : x_e;
  assign beg_ex = sel.beg_neg ? cx_e - a_col : cx_e + a_col;
  assign end_ex = sel.end_neg ? cx_e - a_col : cx_e + a_col;
  assign row_ex = sel.row_neg ? cy_e - a_row : cy_e + a_row;

  // wrap to the coordinate width, flag any lost bits
  assign beg_w = beg_ex[CW-1:0];
  assign end_w = end_ex[CW-1:0];
  assign row_w = row_ex[CW-1:0];
  assign ovf   = (beg_ex != EW'(beg_w)) || (end_ex != EW'(end_w))
              || (row_ex != EW'(row_w));

  always_comb begin
    job_nxt       = job_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    xb_nxt        = xb_r;
    xe_nxt        = xe_r;
    row_nxt       = row_r;
    last_nxt      = last_r;
    done_nxt      = done_r;
    ovf_nxt       = ovf_r;
    if (load_out) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        if (job_r.done) begin
          kind_nxt = fcsg_pkg::KIND_POINT;
          xb_nxt   = '0;
          xe_nxt   = '0;
          row_nxt  = '0;
          last_nxt = 1'b1;
          done_nxt = 1'b1;
          ovf_nxt  = 1'b0;
        end else begin
          kind_nxt = sel.kind;
          xb_nxt   = beg_w;
          xe_nxt   = end_w;
          row_nxt  = row_w;
          last_nxt = step_end;
          done_nxt = 1'b0;
          ovf_nxt  = ovf;
        end
        idx_nxt = idx_r + fcsg_pkg::IDX_W'(1);
        if (step_end) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (pop) begin
      job_nxt  = head_job;
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r  <= job_nxt;
    kind_r <= kind_nxt;
    xb_r   <= xb_nxt;
    xe_r   <= xe_nxt;
    row_r  <= row_nxt;
    last_r <= last_nxt;
    done_r <= done_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_x_begin  = xb_r;
  assign out_x_end    = xe_r;
  assign out_row      = row_r;
  assign out_last     = last_r;
  assign out_done_res = done_r;
  assign out_overflow = ovf_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (last_r && !ovf_r && (kind_r == fcsg_pkg::KIND_POINT)))
    else $error("done result carries primitive data");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == fcsg_pkg::KIND_POINT) && !done_r) |-> (xb_r == xe_r))
    else $error("point with differing ends");

  assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid right after reset");

endmodule

// File: rtl/core/filled_circle_span_generator_top.sv
// filled circle span generator: midpoint circle walk producing points and fill spans
//
// input channel (in_valid / in_stall): a start transaction loads center and
// radius and produces nothing; an advance transaction produces the twelve
// primitives of the current octant step (eight points, then four horizontal
// spans, last set on the twelfth), or one done result once the walk is over.
// result channel (out_valid / out_stall): one primitive per transaction,
// coordinates wrapped to 16 bits with out_overflow raised on a wrap.
// the first primitive of an advance passes through the step queue, the emitter's
// job register and the output register; after that one primitive per cycle
// while out_stall is low. advances are limited by the serial primitive emitter
// and the one result port; start transactions are not queued and give no result.
// a two-entry step queue sits between the walk front end and the emitter, so
// advances are taken while earlier steps are still draining.
// reset (rst_n low, synchronous) empties the queue, drops any pending result
// and returns the walk to its finished state, so an advance gives done.
// when the receiver stalls, the held result stays put, the emitter waits,
// the queue fills and then in_stall rises.
module filled_circle_span_generator_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_operation,
  input  logic signed [fcsg_pkg::CENTER_W-1:0]   in_center_x,
  input  logic signed [fcsg_pkg::CENTER_W-1:0]   in_center_y,
  input  logic        [fcsg_pkg::RADIUS_W-1:0]   in_radius,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_kind,
  output logic signed [fcsg_pkg::COORD_BITS-1:0] out_x_begin,
  output logic signed [fcsg_pkg::COORD_BITS-1:0] out_x_end,
  output logic signed [fcsg_pkg::COORD_BITS-1:0] out_row,
  output logic                                   out_last,
  output logic                                   out_done_res,
  output logic                                   out_overflow
);

  // front to queue
  fcsg_pkg::q_status_t q_st;
  logic                push;
  fcsg_pkg::job_t      push_job;

  // queue to back
  logic                pop;
  fcsg_pkg::job_t      head_job;

  // front: takes transactions, owns the walk state, queues one step per advance
  fcsg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius    (in_radius),
    .q_st         (q_st),
    .push         (push),
    .push_job     (push_job)
  );

  // short queue of pending steps, decouples walk from emission
  fcsg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_st     (q_st),
    .head_job (head_job)
  );

  // back: emits the primitives of each step through a registered output
  fcsg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_st         (q_st),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_x_begin  (out_x_begin),
    .out_x_end    (out_x_end),
    .out_row      (out_row),
    .out_last     (out_last),
    .out_done_res (out_done_res),
    .out_overflow (out_overflow)
  );

endmodule

// File: tb/filled_circle_span_generator_top_test.sv
module filled_circle_span_generator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any transaction on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 3000;
  // random input transactions per idling phase
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_PHASES = 4;
  localparam int DIRECTED_ROWS = 24;
  // radius above this is treated as a large circle and only walked a few steps
  localparam int SMALL_RADIUS_MAX = 20;

  // one primitive as seen on the result channel
  typedef struct packed {
    logic                                   kind;
    logic signed [fcsg_pkg::COORD_BITS-1:0] x_begin;
    logic signed [fcsg_pkg::COORD_BITS-1:0] x_end;
    logic signed [fcsg_pkg::COORD_BITS-1:0] row;
    logic                                   last;
    logic                                   done;
    logic                                   overflow;
  } prim_t;

  // one row of the directed table; lit_done marks a row whose result is a plain done
  typedef struct packed {
    logic                                 op;
    logic signed [fcsg_pkg::CENTER_W-1:0] cx;
    logic signed [fcsg_pkg::CENTER_W-1:0] cy;
    logic        [fcsg_pkg::RADIUS_W-1:0] radius;
    logic                                 lit_done;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic                                   in_operation = fcsg_pkg::OP_START;
  logic signed [fcsg_pkg::CENTER_W-1:0]   in_center_x = '0;
  logic signed [fcsg_pkg::CENTER_W-1:0]   in_center_y = '0;
  logic        [fcsg_pkg::RADIUS_W-1:0]   in_radius = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  logic                                   out_kind;
  logic signed [fcsg_pkg::COORD_BITS-1:0] out_x_begin;
  logic signed [fcsg_pkg::COORD_BITS-1:0] out_x_end;
  logic signed [fcsg_pkg::COORD_BITS-1:0] out_row;
  logic                                   out_last;
  logic                                   out_done_res;
  logic                                   out_overflow;

  filled_circle_span_generator_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius    (in_radius),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_x_begin  (out_x_begin),
    .out_x_end    (out_x_end),
    .out_row      (out_row),
    .out_last     (out_last),
    .out_done_res (out_done_res),
    .out_overflow (out_overflow)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // circle walk mirror: center, current octant point and midpoint error terms
  logic signed [fcsg_pkg::CENTER_W-1:0]  walk_cx = '0;
  logic signed [fcsg_pkg::CENTER_W-1:0]  walk_cy = '0;
  logic signed [fcsg_pkg::RUN_X_W-1:0]   walk_x = -16'sd1;
  logic        [fcsg_pkg::RUN_Y_W-1:0]   walk_y = '0;
  logic signed [fcsg_pkg::ERR_W-1:0]     walk_err = '0;
  logic        [fcsg_pkg::STEP_W-1:0]    inc_x = 17'd1;
  logic        [fcsg_pkg::STEP_W-1:0]    inc_y = 17'd1;
  logic        [fcsg_pkg::TWICE_R_W-1:0] diameter = '0;

  // primitives of the latest step, and every primitive still owed by the block
  prim_t step_prims [fcsg_pkg::NUM_PRIMS];
  int    step_len;
  prim_t expected_prims [$];

  prim_t     got_prim;
  prim_t     want_prim;
  stim_row_t directed_rows [DIRECTED_ROWS];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  // the result carried by an advance once the walk is over
  localparam prim_t DONE_PRIM = '{fcsg_pkg::KIND_POINT, '0, '0, '0, 1'b1, 1'b1, 1'b0};

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // wrap exact coordinates to the result width, flag any that did not fit
  function automatic prim_t make_prim(input logic kind, input longint xb, input longint xe,
                                      input longint yr, input logic last);
    prim_t p;
    logic signed [fcsg_pkg::COORD_BITS-1:0] wb, we, wr;
    wb = xb[fcsg_pkg::COORD_BITS-1:0];
    we = xe[fcsg_pkg::COORD_BITS-1:0];
    wr = yr[fcsg_pkg::COORD_BITS-1:0];
    p.kind     = kind;
    p.x_begin  = wb;
    p.x_end    = we;
    p.row      = wr;
    p.last     = last;
    p.done     = 1'b0;
    p.overflow = (longint'(wb) != xb) || (longint'(we) != xe) || (longint'(wr) != yr);
    return p;
  endfunction

  function automatic bit walk_over();
    return longint'(walk_x) < longint'(walk_y);
  endfunction

  // one accepted input transaction through the walk mirror
  task automatic advance_walk(input logic op, input logic signed [fcsg_pkg::CENTER_W-1:0] sx,
                              input logic signed [fcsg_pkg::CENTER_W-1:0] sy,
                              input logic [fcsg_pkg::RADIUS_W-1:0] sr);
    longint ccx, ccy, px, py;
    step_len = 0;
    if (op == fcsg_pkg::OP_START) begin
      walk_cx  = sx;
      walk_cy  = sy;
      diameter = {sr, 1'b0};
      walk_x   = fcsg_pkg::RUN_X_W'(longint'(sr) - 1);
      walk_y   = '0;
      inc_x    = 17'd1;
      inc_y    = 17'd1;
      walk_err = fcsg_pkg::ERR_W'(64'sd1 - longint'(diameter));
    end else if (walk_over()) begin
      step_prims[0] = DONE_PRIM;
      step_len = 1;
    end else begin
      ccx = walk_cx;
      ccy = walk_cy;
      px  = walk_x;
      py  = walk_y;
      // eight octant points
      step_prims[0]  = make_prim(fcsg_pkg::KIND_POINT, ccx + px, ccx + px, ccy - py, 1'b0);
      step_prims[1]  = make_prim(fcsg_pkg::KIND_POINT, ccx + px, ccx + px, ccy + py, 1'b0);
      step_prims[2]  = make_prim(fcsg_pkg::KIND_POINT, ccx - px, ccx - px, ccy - py, 1'b0);
      step_prims[3]  = make_prim(fcsg_pkg::KIND_POINT, ccx - px, ccx - px, ccy + py, 1'b0);
      step_prims[4]  = make_prim(fcsg_pkg::KIND_POINT, ccx + py, ccx + py, ccy - px, 1'b0);
      step_prims[5]  = make_prim(fcsg_pkg::KIND_POINT, ccx + py, ccx + py, ccy + px, 1'b0);
      step_prims[6]  = make_prim(fcsg_pkg::KIND_POINT, ccx - py, ccx - py, ccy - px, 1'b0);
      step_prims[7]  = make_prim(fcsg_pkg::KIND_POINT, ccx - py, ccx - py, ccy + px, 1'b0);
      // four fill spans, last on the final one
      step_prims[8]  = make_prim(fcsg_pkg::KIND_SPAN, ccx - py, ccx + py, ccy - px, 1'b0);
      step_prims[9]  = make_prim(fcsg_pkg::KIND_SPAN, ccx - px, ccx + px, ccy - py, 1'b0);
      step_prims[10] = make_prim(fcsg_pkg::KIND_SPAN, ccx - px, ccx + px, ccy + py, 1'b0);
      step_prims[11] = make_prim(fcsg_pkg::KIND_SPAN, ccx - py, ccx + py, ccy + px, 1'b1);
      step_len = fcsg_pkg::NUM_PRIMS;
      // midpoint update, each term wrapping at its own width
      if (walk_err <= 0) begin
        walk_y   = walk_y + 1'b1;
        walk_err = fcsg_pkg::ERR_W'(longint'(walk_err) + longint'(inc_y));
        inc_y    = inc_y + 17'd2;
      end
      if (walk_err > 0) begin
        walk_x   = walk_x - 16'sd1;
        inc_x    = inc_x + 17'd2;
        walk_err = fcsg_pkg::ERR_W'(longint'(walk_err) + longint'(inc_x)
                                    - longint'(diameter));
      end
    end
  endtask

  // drive one input transaction, wait for acceptance, then record what it owes
  task automatic send_item(input logic op, input logic signed [fcsg_pkg::CENTER_W-1:0] sx,
                           input logic signed [fcsg_pkg::CENTER_W-1:0] sy,
                           input logic [fcsg_pkg::RADIUS_W-1:0] sr, input logic lit_done);
    // random sender gaps, in_valid held low while the draw stays under gap_pct
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_center_x  <= sx;
    in_center_y  <= sy;
    in_radius    <= sr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_walk(op, sx, sy, sr);
    if (lit_done) begin
      expected_prims.push_back(DONE_PRIM);
    end else begin
      for (int i = 0; i < step_len; i++) expected_prims.push_back(step_prims[i]);
    end
    items_sent++;
  endtask

  // hold the input idle until every owed primitive has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_prims.size() != 0);
  endtask

  // one circle: start, then advances; some cut short, some run past done, some stray
  task automatic run_circle();
    logic signed [fcsg_pkg::CENTER_W-1:0] sx, sy;
    logic [fcsg_pkg::RADIUS_W-1:0] sr;
    int pick, cap, steps, extra;
    pick = $urandom_range(99);
    // stray advance with noise payload
    if (pick < 8) begin
      send_item(fcsg_pkg::OP_ADVANCE, fcsg_pkg::CENTER_W'($urandom),
                fcsg_pkg::CENTER_W'($urandom), fcsg_pkg::RADIUS_W'($urandom), 1'b0);
      return;
    end
    sx = fcsg_pkg::CENTER_W'($urandom);
    sy = fcsg_pkg::CENTER_W'($urandom);
    // centers near the coordinate limits so the circle wraps
    if ($urandom_range(99) < 30) begin
      sx = $urandom_range(1) ? 16'sh7FFF - fcsg_pkg::CENTER_W'($urandom_range(20))
                             : 16'sh8000 + fcsg_pkg::CENTER_W'($urandom_range(20));
      if ($urandom_range(1)) begin
        sy = $urandom_range(1) ? 16'sh7FFF - fcsg_pkg::CENTER_W'($urandom_range(20))
                               : 16'sh8000 + fcsg_pkg::CENTER_W'($urandom_range(20));
      end
    end
    pick = $urandom_range(99);
    if (pick < 80) sr = fcsg_pkg::RADIUS_W'($urandom_range(SMALL_RADIUS_MAX));
    else if (pick < 95) sr = fcsg_pkg::RADIUS_W'($urandom_range(16383));
    else sr = $urandom_range(1) ? {fcsg_pkg::RADIUS_W{1'b1}} : '0;
    send_item(fcsg_pkg::OP_START, sx, sy, sr, 1'b0);
    // broken sequences get cut early, large circles only get a few steps
    if ($urandom_range(99) < 15) cap = $urandom_range(3);
    else if (sr > SMALL_RADIUS_MAX) cap = $urandom_range(1, 6);
    else cap = 40;
    steps = 0;
    while (steps < cap && !walk_over()) begin
      send_item(fcsg_pkg::OP_ADVANCE, fcsg_pkg::CENTER_W'($urandom),
                fcsg_pkg::CENTER_W'($urandom), fcsg_pkg::RADIUS_W'($urandom), 1'b0);
      steps++;
    end
    // a few advances after the walk ended repeat the done result
    if (walk_over()) begin
      extra = $urandom_range(2);
      repeat (extra) begin
        send_item(fcsg_pkg::OP_ADVANCE, fcsg_pkg::CENTER_W'($urandom),
                  fcsg_pkg::CENTER_W'($urandom), fcsg_pkg::RADIUS_W'($urandom), 1'b0);
      end
    end
  endtask

  // receiver stall, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checking against the oldest owed primitive, plus the hang watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        got_prim = '{out_kind, out_x_begin, out_x_end, out_row, out_last,
                     out_done_res, out_overflow};
        if (expected_prims.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: %p", got_prim));
        end else begin
          want_prim = expected_prims.pop_front();
          if (got_prim.kind !== want_prim.kind)
            report_mismatch($sformatf("kind got %0d want %0d", got_prim.kind, want_prim.kind));
          if (got_prim.x_begin !== want_prim.x_begin)
            report_mismatch($sformatf("x_begin got %0d want %0d",
                                      got_prim.x_begin, want_prim.x_begin));
          if (got_prim.x_end !== want_prim.x_end)
            report_mismatch($sformatf("x_end got %0d want %0d",
                                      got_prim.x_end, want_prim.x_end));
          if (got_prim.row !== want_prim.row)
            report_mismatch($sformatf("row got %0d want %0d", got_prim.row, want_prim.row));
          if (got_prim.last !== want_prim.last)
            report_mismatch($sformatf("last got %0d want %0d", got_prim.last, want_prim.last));
          if (got_prim.done !== want_prim.done)
            report_mismatch($sformatf("done_res got %0d want %0d",
                                      got_prim.done, want_prim.done));
          if (got_prim.overflow !== want_prim.overflow)
            report_mismatch($sformatf("overflow got %0d want %0d",
                                      got_prim.overflow, want_prim.overflow));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // idling mix per phase: none, sender gaps, receiver stalls, both
  int gap_by_phase   [NUM_PHASES] = '{0, 80, 0, 33};
  int stall_by_phase [NUM_PHASES] = '{0, 0, 80, 33};

  initial begin
    int phase_goal;
    directed_rows = '{
      // advance straight after reset, twice: walk already finished
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b1},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b1},
      // zero radius gives done at once, and again
      '{fcsg_pkg::OP_START,   16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b1},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b1},
      // unit circle: one step then done
      '{fcsg_pkg::OP_START,   16'sh0000, 16'sh0000, 14'd1, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      // extreme centers with the largest radius, wrapping both ways
      '{fcsg_pkg::OP_START,   16'sh7FFF, 16'sh8000, 14'h3FFF, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_START,   16'sh8000, 16'sh7FFF, 14'h3FFF, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      // center at minus one, walk left unfinished
      '{fcsg_pkg::OP_START,   16'shFFFF, 16'shFFFF, 14'd5, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      // restart in the middle of a walk, then run radius two to done
      '{fcsg_pkg::OP_START,   16'sh0064, 16'shFF9C, 14'd2, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0},
      '{fcsg_pkg::OP_START,   16'sh5A5A, 16'shA5A5, 14'd7, 1'b0},
      '{fcsg_pkg::OP_ADVANCE, 16'sh0000, 16'sh0000, 14'd0, 1'b0}
    };

    // synchronous reset held low from the start, released once
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, no idling
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].cx, directed_rows[i].cy,
                directed_rows[i].radius, directed_rows[i].lit_done);
    end
    // sender holds off until the block has emptied
    drain_results();

    // random circles under each idling mix, draining between phases
    phase_goal = items_sent;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      gap_pct   = gap_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      phase_goal += ITEMS_PER_PHASE;
      while (items_sent < phase_goal) run_circle();
      drain_results();
    end

    // nothing owed; let a few more cycles pass to catch stray results
    stall_pct = 0;
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filled_circle_span_generator_top.f
rtl/core/fcsg_pkg.sv
rtl/core/fcsg_front.sv
rtl/core/fcsg_queue.sv
rtl/core/fcsg_back.sv
rtl/core/filled_circle_span_generator_top.sv
tb/filled_circle_span_generator_top_test.sv
